[sv/bpfm_pkg.sv]
// ----------------------------------------------------------------------------
// Buffer pool frame manager package
// Shared sizes, codes, command and status structs, and helpers.
// ----------------------------------------------------------------------------
package bpfm_pkg;

    localparam int POOL_FRAMES = 16;
    localparam int FRAME_IDX_W = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;

    localparam int MODE_W   = 3;
    localparam int FILE_W   = 16;
    localparam int PAGE_W   = 31;
    localparam int STATUS_W = 2;
    localparam int FRAME_W  = 4;
    localparam int PIN_W    = 8;

    localparam logic [PIN_W-1:0] PIN_MAX  = {PIN_W{1'b1}};
    localparam logic [PIN_W-1:0] PIN_ZERO = '0;
    localparam logic [PIN_W-1:0] PIN_ONE  = {{(PIN_W-1){1'b0}}, 1'b1};

    localparam logic [FRAME_IDX_W-1:0] LAST_FRAME = FRAME_IDX_W'(POOL_FRAMES - 1);

    typedef logic [FRAME_IDX_W-1:0] fidx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_FETCH      = 3'd0,
        MODE_PIN        = 3'd1,
        MODE_UNPIN      = 3'd2,
        MODE_MARK_DIRTY = 3'd3,
        MODE_FLUSH_PAGE = 3'd4,
        MODE_FLUSH_ALL  = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK           = 2'd0,
        STAT_NOT_RESIDENT = 2'd1,
        STAT_UNPIN_ZERO   = 2'd2,
        STAT_ALL_PINNED   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_EXEC,
        ST_FLUSH,
        ST_FLUSH_END
    } state_t;

    typedef struct packed {
        logic latch;
        logic lookup;
        logic decide;
        logic exec;
        logic flush_step;
        logic flush_end;
    } ctrl_cmd_t;

    typedef struct packed {
        logic flush_all;
        logic scan_last;
    } dp_status_t;

    // Frame index as carried on the 4-bit result field.
    function automatic logic [FRAME_W-1:0] frame_field(fidx_t idx);
        logic [FRAME_IDX_W+FRAME_W-1:0] ext;
        ext = {{FRAME_W{1'b0}}, idx};
        return ext[FRAME_W-1:0];
    endfunction

endpackage

[sv/bpfm_ctrl.sv]
// ----------------------------------------------------------------------------
// Buffer pool frame manager controller
// Sequences lookup, decision, execution and the flush-all sweep.
// ----------------------------------------------------------------------------
module bpfm_ctrl
    import bpfm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = dp_status.flush_all ? ST_FLUSH : ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FLUSH:
            begin
                cmd.flush_step = 1'b1;
                if (dp_status.scan_last)
                begin
                    state_next = ST_FLUSH_END;
                end
            end
            ST_FLUSH_END:
            begin
                cmd.flush_end = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/bpfm_datapath.sv]
// ----------------------------------------------------------------------------
// Buffer pool frame manager datapath
// Frame table, tag match, clock victim search and result registers.
// ----------------------------------------------------------------------------
module bpfm_datapath
    import bpfm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          dp_status,
    input  logic [MODE_W-1:0]   mode,
    input  logic [FILE_W-1:0]   file_id,
    input  logic [PAGE_W-1:0]   page_id,
    output logic                result_valid,
    output logic [STATUS_W-1:0] status,
    output logic [FRAME_W-1:0]  frame,
    output logic                hit,
    output logic                load_valid,
    output logic                writeback_valid,
    output logic [FILE_W-1:0]   writeback_file,
    output logic [PAGE_W-1:0]   writeback_page,
    output logic                last
);

    // Request registers.
    logic [MODE_W-1:0] req_mode_reg;
    logic [FILE_W-1:0] req_file_reg;
    logic [PAGE_W-1:0] req_page_reg;

    // Frame table.
    logic [FILE_W-1:0] tag_file_reg [POOL_FRAMES];
    logic [PAGE_W-1:0] tag_page_reg [POOL_FRAMES];
    logic              valid_reg    [POOL_FRAMES];
    logic              dirty_reg    [POOL_FRAMES];
    logic [PIN_W-1:0]  pin_reg      [POOL_FRAMES];
    fidx_t             hand_reg;

    // Lookup and decision results.
    logic [POOL_FRAMES-1:0] match_vec_reg, match_vec_next;
    logic [POOL_FRAMES-1:0] cand_vec_reg,  cand_vec_next;
    logic                   hit_found_reg, hit_found_next;
    fidx_t                  hit_idx_reg,   hit_idx_next;
    logic                   victim_found_reg, victim_found_next;
    fidx_t                  victim_idx_reg,   victim_idx_next;
    fidx_t                  scan_reg;

    // Table update controls.
    logic  do_pin_inc, do_pin_dec, do_set_dirty, do_clr_dirty, do_alloc;
    fidx_t upd_idx;
    logic  scan_dirty;

    // Result registers.
    logic                result_valid_reg, result_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic                hit_reg, hit_next;
    logic                load_reg, load_next;
    logic                wb_reg, wb_next;
    logic [FILE_W-1:0]   wb_file_reg, wb_file_next;
    logic [PAGE_W-1:0]   wb_page_reg, wb_page_next;
    logic                last_reg, last_next;

    assign dp_status.flush_all = (req_mode_reg == MODE_FLUSH_ALL);
    assign dp_status.scan_last = (scan_reg == LAST_FRAME);

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_mode_reg <= mode;
            req_file_reg <= file_id;
            req_page_reg <= page_id;
        end
    end

    // Parallel tag compare and replacement candidates.
    always_comb
    begin
        for (int i = 0; i < POOL_FRAMES; i++)
        begin
            match_vec_next[i] = valid_reg[i] && (tag_file_reg[i] == req_file_reg)
                                && (tag_page_reg[i] == req_page_reg);
            cand_vec_next[i]  = !valid_reg[i] || (pin_reg[i] == PIN_ZERO);
        end
    end

    // Lowest matching frame, and first candidate after the hand.
    always_comb
    begin
        logic [FRAME_IDX_W:0] pos;
        hit_found_next    = 1'b0;
        hit_idx_next      = '0;
        victim_found_next = 1'b0;
        victim_idx_next   = '0;
        for (int i = POOL_FRAMES - 1; i >= 0; i--)
        begin
            if (match_vec_reg[i])
            begin
                hit_found_next = 1'b1;
                hit_idx_next   = FRAME_IDX_W'(i);
            end
        end
        for (int k = POOL_FRAMES - 1; k >= 0; k--)
        begin
            pos = {1'b0, hand_reg} + (FRAME_IDX_W + 1)'(k + 1);
            if (pos >= (FRAME_IDX_W + 1)'(POOL_FRAMES))
            begin
                pos = pos - (FRAME_IDX_W + 1)'(POOL_FRAMES);
            end
            if (cand_vec_reg[pos[FRAME_IDX_W-1:0]])
            begin
                victim_found_next = 1'b1;
                victim_idx_next   = pos[FRAME_IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            match_vec_reg <= match_vec_next;
            cand_vec_reg  <= cand_vec_next;
        end
        if (cmd.decide)
        begin
            hit_found_reg    <= hit_found_next;
            hit_idx_reg      <= hit_idx_next;
            victim_found_reg <= victim_found_next;
            victim_idx_reg   <= victim_idx_next;
        end
    end

    assign scan_dirty = valid_reg[scan_reg] && dirty_reg[scan_reg];

    // Execution: table update controls and the result of the transaction.
    always_comb
    begin
        do_pin_inc   = 1'b0;
        do_pin_dec   = 1'b0;
        do_set_dirty = 1'b0;
        do_clr_dirty = 1'b0;
        do_alloc     = 1'b0;
        upd_idx      = hit_idx_reg;

        result_valid_next = 1'b0;
        status_next       = STAT_OK;
        frame_next        = '0;
        hit_next          = 1'b0;
        load_next         = 1'b0;
        wb_next           = 1'b0;
        wb_file_next      = '0;
        wb_page_next      = '0;
        last_next         = 1'b1;

        if (cmd.exec)
        begin
            result_valid_next = 1'b1;
            case (req_mode_reg)
                MODE_FETCH:
                begin
                    if (hit_found_reg)
                    begin
                        do_pin_inc = 1'b1;
                        frame_next = frame_field(hit_idx_reg);
                        hit_next   = 1'b1;
                    end
                    else if (victim_found_reg)
                    begin
                        upd_idx    = victim_idx_reg;
                        do_alloc   = 1'b1;
                        frame_next = frame_field(victim_idx_reg);
                        load_next  = 1'b1;
                        if (valid_reg[victim_idx_reg] && dirty_reg[victim_idx_reg])
                        begin
                            wb_next      = 1'b1;
                            wb_file_next = tag_file_reg[victim_idx_reg];
                            wb_page_next = tag_page_reg[victim_idx_reg];
                        end
                    end
                    else
                    begin
                        status_next = STAT_ALL_PINNED;
                    end
                end
                MODE_PIN, MODE_UNPIN, MODE_MARK_DIRTY, MODE_FLUSH_PAGE:
                begin
                    if (!hit_found_reg)
                    begin
                        status_next = STAT_NOT_RESIDENT;
                    end
                    else
                    begin
                        frame_next = frame_field(hit_idx_reg);
                        case (req_mode_reg)
                            MODE_PIN:
                            begin
                                do_pin_inc = 1'b1;
                            end
                            MODE_UNPIN:
                            begin
                                if (pin_reg[hit_idx_reg] == PIN_ZERO)
                                begin
                                    status_next = STAT_UNPIN_ZERO;
                                end
                                else
                                begin
                                    do_pin_dec = 1'b1;
                                end
                            end
                            MODE_MARK_DIRTY:
                            begin
                                do_set_dirty = 1'b1;
                            end
                            default:
                            begin
                                do_clr_dirty = 1'b1;
                                if (dirty_reg[hit_idx_reg])
                                begin
                                    wb_next      = 1'b1;
                                    wb_file_next = tag_file_reg[hit_idx_reg];
                                    wb_page_next = tag_page_reg[hit_idx_reg];
                                end
                            end
                        endcase
                    end
                end
                default:
                begin
                    // Unknown modes answer with an all-zero final result.
                end
            endcase
        end
        else if (cmd.flush_step)
        begin
            upd_idx = scan_reg;
            if (scan_dirty)
            begin
                do_clr_dirty      = 1'b1;
                result_valid_next = 1'b1;
                frame_next        = frame_field(scan_reg);
                wb_next           = 1'b1;
                wb_file_next      = tag_file_reg[scan_reg];
                wb_page_next      = tag_page_reg[scan_reg];
                last_next         = 1'b0;
            end
        end
        else if (cmd.flush_end)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_FRAMES; i++)
            begin
                valid_reg[i] <= 1'b0;
                dirty_reg[i] <= 1'b0;
                pin_reg[i]   <= PIN_ZERO;
            end
            hand_reg <= '0;
            scan_reg <= '0;
        end
        else
        begin
            if (cmd.latch)
            begin
                scan_reg <= '0;
            end
            else if (cmd.flush_step && !dp_status.scan_last)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (do_alloc)
            begin
                hand_reg           <= upd_idx;
                valid_reg[upd_idx] <= 1'b1;
                dirty_reg[upd_idx] <= 1'b0;
                pin_reg[upd_idx]   <= PIN_ONE;
            end
            if (do_pin_inc && (pin_reg[upd_idx] != PIN_MAX))
            begin
                pin_reg[upd_idx] <= pin_reg[upd_idx] + PIN_ONE;
            end
            if (do_pin_dec)
            begin
                pin_reg[upd_idx] <= pin_reg[upd_idx] - PIN_ONE;
            end
            if (do_set_dirty)
            begin
                dirty_reg[upd_idx] <= 1'b1;
            end
            if (do_clr_dirty)
            begin
                dirty_reg[upd_idx] <= 1'b0;
            end
        end
    end

    // Tags have no reset; they are only ever read behind a valid bit.
    always_ff @(posedge clk)
    begin
        if (do_alloc)
        begin
            tag_file_reg[upd_idx] <= req_file_reg;
            tag_page_reg[upd_idx] <= req_page_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        frame_reg   <= frame_next;
        hit_reg     <= hit_next;
        load_reg    <= load_next;
        wb_reg      <= wb_next;
        wb_file_reg <= wb_file_next;
        wb_page_reg <= wb_page_next;
        last_reg    <= last_next;
    end

    assign result_valid    = result_valid_reg;
    assign status          = status_reg;
    assign frame           = frame_reg;
    assign hit             = hit_reg;
    assign load_valid      = load_reg;
    assign writeback_valid = wb_reg;
    assign writeback_file  = wb_file_reg;
    assign writeback_page  = wb_page_reg;
    assign last            = last_reg;

endmodule

[sv/buffer_pool_frame_manager_core.sv]
// ----------------------------------------------------------------------------
// Buffer pool frame manager core
// Frame table with pin counts, dirty tracking and clock replacement.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction (mode, file_id, page_id) is taken on a rising edge
//   with start high and busy low. Results come out on the result ports, each
//   valid for exactly one cycle while result_valid is high; last marks the
//   final result of a request. The receiver cannot stall, so it must take
//   every result in the cycle it is shown.
//   Fetch, pin, unpin, mark dirty, flush page and unknown modes give one
//   result, shown in the same cycle as busy drops; a new request may be
//   accepted in that cycle, so a request passes through latch, tag compare,
//   match and victim priority select and table update before the next one
//   is taken.
//   Flush all walks the frame table one frame per cycle: it gives one result
//   per dirty frame and a final result.
//   Reset clears the valid, dirty and pin state of every frame and the clock
//   hand at once; the block accepts requests right after reset.
// ----------------------------------------------------------------------------
module buffer_pool_frame_manager_core
    import bpfm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [MODE_W-1:0]   mode,
    input  logic [FILE_W-1:0]   file_id,
    input  logic [PAGE_W-1:0]   page_id,
    output logic                result_valid,
    output logic [STATUS_W-1:0] status,
    output logic [FRAME_W-1:0]  frame,
    output logic                hit,
    output logic                load_valid,
    output logic                writeback_valid,
    output logic [FILE_W-1:0]   writeback_file,
    output logic [PAGE_W-1:0]   writeback_page,
    output logic                last
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    bpfm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    bpfm_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .dp_status       (dp_status),
        .mode            (mode),
        .file_id         (file_id),
        .page_id         (page_id),
        .result_valid    (result_valid),
        .status          (status),
        .frame           (frame),
        .hit             (hit),
        .load_valid      (load_valid),
        .writeback_valid (writeback_valid),
        .writeback_file  (writeback_file),
        .writeback_page  (writeback_page),
        .last            (last)
    );

endmodule

[sv/bpfm_checker.sv]
// ----------------------------------------------------------------------------
// Buffer pool frame manager checker
// Port-level properties of the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module bpfm_checker
    import bpfm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                result_valid,
    input logic [STATUS_W-1:0] status,
    input logic                hit,
    input logic                load_valid,
    input logic                writeback_valid,
    input logic [FILE_W-1:0]   writeback_file,
    input logic [PAGE_W-1:0]   writeback_page,
    input logic                last
);

    // A request transaction keeps the block busy and silent in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !result_valid)
        else $error("accepted request did not occupy the block");

    // The final result of a request appears as the block goes idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
        else $error("final result shown while busy");

    // Intermediate flush results only appear while the sweep is running.
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy && writeback_valid)
        else $error("intermediate result outside a flush sweep");

    // Error results carry no command.
    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != STAT_OK) |-> !hit && !load_valid && !writeback_valid)
        else $error("error result carries a command");

    // Writeback tag is zero when no writeback is requested.
    a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !writeback_valid |-> writeback_file == '0 && writeback_page == '0)
        else $error("writeback tag set without writeback");

endmodule

bind buffer_pool_frame_manager_core bpfm_checker u_bpfm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .result_valid    (result_valid),
    .status          (status),
    .hit             (hit),
    .load_valid      (load_valid),
    .writeback_valid (writeback_valid),
    .writeback_file  (writeback_file),
    .writeback_page  (writeback_page),
    .last            (last)
);
